>>> rtl/core/heq_pkg.sv
// Shared types, constants and defaults for the histogram equalizer.
`default_nettype none
package heq_pkg;

    localparam int DEF_BIN_COUNT  = 256;
    localparam int DEF_COUNT_BITS = 32;
    localparam int DATA_W         = 16;
    localparam int BIN_OUT_W      = 8;
    localparam logic [DATA_W-1:0] TARGET_RESET = 16'd255;
    localparam logic [DATA_W-1:0] RANGE_LOW_RESET = 16'hFFFF;
    localparam logic [DATA_W-1:0] RANGE_HIGH_RESET = 16'h0000;

    // Register index of the output scale on the configuration port.
    localparam logic REG_OUT_SCALE = 1'b0;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_RANGE = 2'd1,
        OP_HIST  = 2'd2,
        OP_MAP   = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] intensity;
    } cmd_t;

    typedef struct packed {
        logic                 range_zero;
        logic [BIN_OUT_W-1:0] bin_index;
        logic [DATA_W-1:0]    mapped_intensity;
    } res_t;

    typedef struct packed {
        logic init_done;
    } back_status_t;

endpackage
`default_nettype wire

>>> rtl/core/heq_front.sv
// Front end: accepts input requests and decodes them into queue commands.
`default_nettype none
module heq_front (
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [15:0]                s_tdata,   // [15:0] intensity
    input  wire logic [1:0]                 s_tuser,   // [1:0] op
    input  wire heq_pkg::back_status_t      status,
    input  wire logic                       q_full,
    output logic                            q_push,
    output heq_pkg::cmd_t                   q_data
);

    logic accept;

    // Hold off requests until the count memory has been swept after reset
    assign s_tready = status.init_done && !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    // Decode the selector into a command
    always_comb begin
        q_data.intensity = s_tdata;
        q_data.op        = heq_pkg::op_t'(s_tuser);
    end

endmodule
`default_nettype wire

>>> rtl/core/heq_fifo.sv
// Two-entry command queue between the front and back ends.
`default_nettype none
module heq_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire heq_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output heq_pkg::cmd_t      pop_data,
    output logic               empty
);

    heq_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Store payload
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)      count_reg <= count_reg + 2'd1;
            else if (pop && !push) count_reg <= count_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/heq_div.sv
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
`default_nettype none
module heq_div #(
    parameter int DEN_W = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DEN_W+15:0]     num,
    input  wire logic [DEN_W-1:0]      den,
    output logic                       done,
    output logic [15:0]                quot
);

    logic [DEN_W-1:0] rem_reg, den_reg;
    logic [15:0]      num_reg, quot_reg;
    logic [4:0]       cnt_reg;
    logic             run_reg, done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, num_reg[15]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign done  = done_reg;
    assign quot  = quot_reg;

    // Datapath: shift in one numerator bit, subtract when it fits
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num[DEN_W+15:16];
            num_reg  <= num[15:0];
            den_reg  <= den;
        end else if (run_reg) begin
            rem_reg  <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            num_reg  <= {num_reg[14:0], 1'b0};
            quot_reg <= {quot_reg[14:0], fits};
        end
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            done_reg <= run_reg && !start && (cnt_reg == 5'd15);
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= 5'd0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd15) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/heq_back.sv
// Back end: range tracking, binning, Fenwick-tree counts and mapping.
`default_nettype none
module heq_back #(
    parameter int BIN_COUNT  = heq_pkg::DEF_BIN_COUNT,
    parameter int COUNT_BITS = heq_pkg::DEF_COUNT_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_empty,
    input  wire heq_pkg::cmd_t         q_data,
    output logic                       q_pop,
    input  wire logic [15:0]           out_scale,
    output heq_pkg::back_status_t      status,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output heq_pkg::res_t              m_res
);

    localparam int BINW   = $clog2(BIN_COUNT);
    localparam int IW     = $clog2(BIN_COUNT + 1);
    localparam int CHUNKS = (COUNT_BITS + 15) / 16;
    localparam int AW     = CHUNKS * 16 + 16;
    localparam int DDW    = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int DNW    = DDW + 16;
    localparam int KW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int BNW    = 16 + BINW;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam logic [BINW-1:0] BIN_TOP = BINW'(BIN_COUNT - 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_BMUL, ST_BWAIT, ST_ROUTE, ST_URD, ST_UWR,
        ST_QRD, ST_QACC, ST_MUL, ST_MWAIT, ST_OUT
    } state_t;

    state_t                 state_reg;
    heq_pkg::op_t           op_reg;
    logic [15:0]            x_reg, low_reg, high_reg;
    logic [BINW-1:0]        bin_reg;
    logic [IW-1:0]          idx_reg;
    logic [BINW:0]          clr_reg;
    logic [COUNT_BITS-1:0]  total_reg, acc_reg, rdata_reg;
    logic [AW-1:0]          prod_reg;
    logic [KW-1:0]          k_reg;
    logic [DNW-1:0]         num_reg;
    logic [DDW-1:0]         den_reg;
    logic                   go_reg, init_reg, out_valid_reg;
    heq_pkg::res_t          res_reg, out_reg;

    logic [COUNT_BITS-1:0]  mem [BIN_COUNT];

    logic                   mem_we;
    logic [BINW-1:0]        mem_waddr, mem_raddr;
    logic [COUNT_BITS-1:0]  mem_wdata;
    logic [IW-1:0]          idx_low, idx_down;
    logic [IW:0]            idx_up;
    logic [COUNT_BITS:0]    acc_sum;
    logic [COUNT_BITS-1:0]  acc_sat, rdata_inc, total_inc;
    logic [CHUNKS*16-1:0]   acc_pad;
    logic [AW-1:0]          term, prod_sum;
    logic                   range_zero;
    logic                   div_done;
    logic [15:0]            div_quot;
    logic [BNW-1:0]         bin_num;
    logic [BINW+7:0]        bin_wide;

    assign status.init_done = init_reg;
    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;
    assign q_pop   = (state_reg == ST_IDLE) && !q_empty;

    // Fenwick index arithmetic
    assign idx_low   = idx_reg & (~idx_reg + IW'(1));
    assign idx_up    = {1'b0, idx_reg} + {1'b0, idx_low};
    assign idx_down  = idx_reg - idx_low;
    assign mem_raddr = BINW'(idx_reg - IW'(1));

    // Saturating counts
    assign rdata_inc = (rdata_reg == CMAX) ? CMAX : rdata_reg + COUNT_BITS'(1);
    assign total_inc = (total_reg == CMAX) ? CMAX : total_reg + COUNT_BITS'(1);
    assign acc_sum   = {1'b0, acc_reg} + {1'b0, rdata_reg};
    assign acc_sat   = acc_sum[COUNT_BITS] ? CMAX : acc_sum[COUNT_BITS-1:0];

    // One 16x16 partial product of count times scale per cycle
    assign acc_pad  = (CHUNKS * 16)'(acc_reg);
    assign term     = AW'({16'd0, acc_pad[k_reg*16 +: 16]} * {16'd0, out_scale})
                      << (k_reg * 16);
    assign prod_sum = prod_reg + term;

    assign range_zero = (high_reg <= low_reg);
    assign bin_num    = BNW'(x_reg - low_reg) * BNW'(BIN_TOP);
    assign bin_wide   = {8'd0, bin_reg};

    // Memory write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = mem_raddr;
        mem_wdata = rdata_inc;
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg[BINW-1:0];
            mem_wdata = '0;
        end else if (state_reg == ST_UWR) begin
            mem_we = 1'b1;
        end
    end

    // Count memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    heq_div #(.DEN_W(DDW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (go_reg),
        .num     (num_reg),
        .den     (den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            init_reg      <= 1'b0;
            clr_reg       <= '0;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            low_reg       <= heq_pkg::RANGE_LOW_RESET;
            high_reg      <= heq_pkg::RANGE_HIGH_RESET;
            total_reg     <= '0;
        end else begin
            // Start the divider once its operands are loaded
            go_reg <= (state_reg == ST_BMUL) ||
                      ((state_reg == ST_MUL) && (k_reg == KW'(CHUNKS - 1)));
            if (out_valid_reg && m_ready && state_reg != ST_OUT) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + (BINW + 1)'(1);
                    if (clr_reg == (BINW + 1)'(BIN_COUNT - 1)) begin
                        init_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (!q_empty) begin
                        op_reg <= q_data.op;
                        x_reg  <= q_data.intensity;
                        unique case (q_data.op)
                            heq_pkg::OP_CLEAR: begin
                                low_reg   <= heq_pkg::RANGE_LOW_RESET;
                                high_reg  <= heq_pkg::RANGE_HIGH_RESET;
                                total_reg <= '0;
                                clr_reg   <= '0;
                                state_reg <= ST_CLEAR;
                            end
                            heq_pkg::OP_RANGE: begin
                                if (q_data.intensity < low_reg)  low_reg  <= q_data.intensity;
                                if (q_data.intensity > high_reg) high_reg <= q_data.intensity;
                            end
                            default: begin
                                if (range_zero) begin
                                    bin_reg <= '0;
                                    if (q_data.op == heq_pkg::OP_MAP) begin
                                        res_reg.mapped_intensity <= q_data.intensity;
                                        res_reg.bin_index        <= '0;
                                        res_reg.range_zero       <= 1'b1;
                                        state_reg                <= ST_OUT;
                                    end else begin
                                        state_reg <= ST_ROUTE;
                                    end
                                end else if (q_data.intensity <= low_reg) begin
                                    bin_reg   <= '0;
                                    state_reg <= ST_ROUTE;
                                end else if (q_data.intensity >= high_reg) begin
                                    bin_reg   <= BIN_TOP;
                                    state_reg <= ST_ROUTE;
                                end else begin
                                    state_reg <= ST_BMUL;
                                end
                            end
                        endcase
                    end
                end
                ST_BMUL: begin
                    num_reg   <= DNW'(bin_num);
                    den_reg   <= DDW'(high_reg - low_reg);
                    state_reg <= ST_BWAIT;
                end
                ST_BWAIT: begin
                    if (div_done) begin
                        bin_reg   <= div_quot[BINW-1:0];
                        state_reg <= ST_ROUTE;
                    end
                end
                ST_ROUTE: begin
                    idx_reg   <= IW'(bin_reg) + IW'(1);
                    acc_reg   <= '0;
                    state_reg <= (op_reg == heq_pkg::OP_HIST) ? ST_URD : ST_QRD;
                end
                ST_URD: begin
                    state_reg <= ST_UWR;
                end
                ST_UWR: begin
                    // Climb to the next covering node, stop past the top
                    if (idx_up > (IW + 1)'(BIN_COUNT)) begin
                        total_reg <= total_inc;
                        state_reg <= ST_IDLE;
                    end else begin
                        idx_reg   <= idx_up[IW-1:0];
                        state_reg <= ST_URD;
                    end
                end
                ST_QRD: begin
                    state_reg <= ST_QACC;
                end
                ST_QACC: begin
                    acc_reg <= acc_sat;
                    idx_reg <= idx_down;
                    if (idx_down == '0) begin
                        if (total_reg == '0) begin
                            res_reg.mapped_intensity <= '0;
                            res_reg.bin_index        <= bin_wide[7:0];
                            res_reg.range_zero       <= 1'b0;
                            state_reg                <= ST_OUT;
                        end else begin
                            k_reg     <= '0;
                            prod_reg  <= '0;
                            state_reg <= ST_MUL;
                        end
                    end else begin
                        state_reg <= ST_QRD;
                    end
                end
                ST_MUL: begin
                    prod_reg <= prod_sum;
                    k_reg    <= k_reg + KW'(1);
                    if (k_reg == KW'(CHUNKS - 1)) begin
                        num_reg   <= prod_sum[DNW-1:0];
                        den_reg   <= DDW'(total_reg);
                        state_reg <= ST_MWAIT;
                    end
                end
                ST_MWAIT: begin
                    if (div_done) begin
                        res_reg.mapped_intensity <= div_quot;
                        res_reg.bin_index        <= bin_wide[7:0];
                        res_reg.range_zero       <= 1'b0;
                        state_reg                <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/histogram_equalizer.sv
// Top level of the histogram equalizer: APB register, front, queue and back.
// Histogram and map requests are paced by the 16-step divider and the Fenwick walk over the
// count memory, which has a separate write and read port. One request at a time.
// After reset the count memory is swept with s_tready low.
// Reset is synchronous, active low; the output scale register resets to 255.
`default_nettype none
module histogram_equalizer #(
    parameter int BIN_COUNT  = heq_pkg::DEF_BIN_COUNT,
    parameter int COUNT_BITS = heq_pkg::DEF_COUNT_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] intensity
    input  wire logic [1:0]  s_tuser,   // [1:0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [15:0] mapped_intensity, [23:16] bin_index
    output logic [0:0]       m_tuser,   // [0] range_zero
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0]           target_reg;
    heq_pkg::back_status_t status;
    heq_pkg::cmd_t         push_data, pop_data;
    heq_pkg::res_t         res;
    logic                  push, pop, full, empty;

    // Configuration register
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= heq_pkg::TARGET_RESET;
        end else if (psel && penable && pwrite && paddr[2] == heq_pkg::REG_OUT_SCALE) begin
            target_reg <= pwdata[15:0];
        end
    end
    assign prdata = (paddr[2] == heq_pkg::REG_OUT_SCALE) ? {16'd0, target_reg} : 32'd0;

    heq_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .status   (status),
        .q_full   (full),
        .q_push   (push),
        .q_data   (push_data)
    );

    heq_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    heq_back #(
        .BIN_COUNT  (BIN_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (empty),
        .q_data     (pop_data),
        .q_pop      (pop),
        .out_scale  (target_reg),
        .status     (status),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_res      (res)
    );

    // Pack the result
    assign m_tdata = {res.bin_index, res.mapped_intensity};
    assign m_tuser = res.range_zero;

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the histogram equalizer: directed passes, random passes, pressure.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] intensity
    logic [1:0]  s_tuser;   // [1:0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [15:0] mapped_intensity, [23:16] bin_index
    logic [0:0]  m_tuser;   // [0] range_zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    histogram_equalizer dut (.*);

    // Predictor state
    logic [15:0]    eq_target;
    logic [15:0]    eq_low;
    logic [15:0]    eq_high;
    logic [31:0]    eq_cum [256];
    logic [31:0]    eq_total;
    heq_pkg::res_t  mapped_queue[$];

    int  mismatches;
    int  results_seen;
    int  map_requests;
    bit  idle_enable;
    int  hold_cycles;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void clear_predictor();
        eq_low = heq_pkg::RANGE_LOW_RESET;
        eq_high = heq_pkg::RANGE_HIGH_RESET;
        for (int i = 0; i < 256; i++) eq_cum[i] = '0;
        eq_total = '0;
    endfunction

    function automatic logic [7:0] bin_for(logic [15:0] x);
        logic [39:0] q;
        if (x <= eq_low) return 8'd0;
        if (x >= eq_high) return 8'd255;
        q = (40'(x - eq_low) * 40'd255) / 40'(eq_high - eq_low);
        if (q > 40'd255) q = 40'd255;
        return q[7:0];
    endfunction

    // Advance the predictor by one accepted request
    function automatic void predict_request(heq_pkg::op_t op, logic [15:0] x);
        logic       rz;
        logic [7:0] b;
        logic [63:0] m;
        heq_pkg::res_t r;
        rz = (eq_high <= eq_low);
        b = rz ? 8'd0 : bin_for(x);
        case (op)
            heq_pkg::OP_CLEAR: clear_predictor();
            heq_pkg::OP_RANGE: begin
                if (x < eq_low) eq_low = x;
                if (x > eq_high) eq_high = x;
            end
            heq_pkg::OP_HIST: begin
                for (int i = b; i < 256; i++)
                    if (eq_cum[i] != 32'hFFFF_FFFF) eq_cum[i]++;
                if (eq_total != 32'hFFFF_FFFF) eq_total++;
            end
            default: begin
                if (rz) begin
                    r.mapped_intensity = x;
                    r.bin_index = 8'd0;
                    r.range_zero = 1'b1;
                end else begin
                    m = 0;
                    if (eq_total != 0) m = (64'(eq_cum[b]) * 64'(eq_target)) / 64'(eq_total);
                    r.mapped_intensity = m[15:0];
                    r.bin_index = b;
                    r.range_zero = 1'b0;
                end
                mapped_queue.insert(mapped_queue.size(), r);
                map_requests++;
            end
        endcase
    endfunction

    // Send one request, idling at random beforehand; valid stays up until the next idle
    task automatic send_request(heq_pkg::op_t op, logic [15:0] x);
        while (idle_enable && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= x;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(op, x);
    endtask

    // Drop valid, hold until every expected result has come, then let the block settle
    task automatic drain();
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        while (mapped_queue.size() != 0 && n < 200000) begin
            @(posedge aclk);
            n++;
        end
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_target(logic [15:0] v);
        logic [31:0] rd;
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(int'(heq_pkg::REG_OUT_SCALE) * 4); pwdata <= {16'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        eq_target = v;
        pwrite <= 1'b0; penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata;
        psel <= 1'b0; penable <= 1'b0;
        if (rd[15:0] != v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("register readback: expected %0d actual %0d", v, rd[15:0]);
        end
    endtask

    // Result receiver: random stalls plus the long hold-off
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(idle_enable && $urandom_range(99) < 14);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        heq_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (mapped_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = mapped_queue.pop_front();
                if (m_tdata[15:0] != want.mapped_intensity ||
                    m_tdata[23:16] != want.bin_index || m_tuser[0] != want.range_zero) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mapped mismatch: expected %0d/%0d/%0d actual %0d/%0d/%0d",
                                 want.mapped_intensity, want.bin_index, want.range_zero,
                                 m_tdata[15:0], m_tdata[23:16], m_tuser[0]);
                end
            end
        end
    end

    // Map on an empty, zero-range state, then the field extremes
    task automatic test_special_cases();
        send_request(heq_pkg::OP_MAP, 16'hFFFF);
        send_request(heq_pkg::OP_MAP, 16'h0000);
        send_request(heq_pkg::OP_HIST, 16'h1234);
        send_request(heq_pkg::OP_MAP, 16'h5555);
        send_request(heq_pkg::OP_CLEAR, 16'hAAAA);
        send_request(heq_pkg::OP_RANGE, 16'h0000);
        send_request(heq_pkg::OP_RANGE, 16'hFFFF);
        send_request(heq_pkg::OP_MAP, 16'h8000);
        send_request(heq_pkg::OP_HIST, 16'h0000);
        send_request(heq_pkg::OP_HIST, 16'hFFFF);
        send_request(heq_pkg::OP_HIST, 16'h7FFF);
        send_request(heq_pkg::OP_MAP, 16'h0000);
        send_request(heq_pkg::OP_MAP, 16'h7FFF);
        send_request(heq_pkg::OP_MAP, 16'hFFFF);
        send_request(heq_pkg::OP_CLEAR, 16'h0);
        send_request(heq_pkg::OP_RANGE, 16'd100);
        send_request(heq_pkg::OP_RANGE, 16'd200);
        send_request(heq_pkg::OP_HIST, 16'd50);
        send_request(heq_pkg::OP_HIST, 16'd250);
        send_request(heq_pkg::OP_MAP, 16'd10);
        send_request(heq_pkg::OP_MAP, 16'd150);
        send_request(heq_pkg::OP_MAP, 16'd60000);
        drain();
    endtask

    // One equalization frame: clear, range, histogram, map, random content
    task automatic run_frame(int n);
        logic [15:0] lo, hi;
        lo = 16'($urandom);
        hi = ($urandom_range(3) == 0) ? lo : 16'($urandom);
        send_request(heq_pkg::OP_CLEAR, 16'($urandom));
        for (int i = 0; i < n / 4 + 1; i++)
            send_request(heq_pkg::OP_RANGE, (i % 2) ? lo : (i == 2 ? hi : 16'($urandom)));
        for (int i = 0; i < n; i++)
            send_request(heq_pkg::OP_HIST, 16'($urandom));
        for (int i = 0; i < n; i++)
            send_request(heq_pkg::OP_MAP, 16'($urandom));
    endtask

    // Frames under several target settings, extremes included
    task automatic test_random_frames();
        logic [15:0] targets[5];
        targets = '{16'd1, 16'd65535, 16'd0, 16'd1000, 16'd255};
        foreach (targets[t]) begin
            write_target(targets[t]);
            for (int f = 0; f < 6; f++) run_frame($urandom_range(4, 14));
            drain();
        end
        write_target(16'($urandom_range(1, 65535)));
    endtask

    // Noise: random ops including clears mid-frame
    task automatic test_random_noise();
        for (int i = 0; i < 390; i++)
            send_request(heq_pkg::op_t'($urandom_range(3)), 16'($urandom));
        drain();
    endtask

    // Long receiver hold-off while requests keep coming, then a full pause
    task automatic test_backpressure();
        idle_enable = 1'b0;
        hold_cycles = 3000;
        run_frame(20);
        for (int i = 0; i < 30; i++) send_request(heq_pkg::OP_MAP, 16'($urandom));
        drain();
        idle_enable = 1'b1;
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatches = 0; results_seen = 0; map_requests = 0;
        idle_enable = 1'b1; hold_cycles = 0;
        eq_target = heq_pkg::TARGET_RESET;
        clear_predictor();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_special_cases();
        test_random_frames();
        test_backpressure();
        test_random_noise();
        drain();
        if (mapped_queue.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", mapped_queue.size());
        end
        $display("covered clear/range/histogram/map passes, zero range, empty histogram,");
        $display("targets 0..65535, long hold-off: %0d map requests, %0d results checked",
                 map_requests, results_seen);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
